@@ rtl/core/header_trailer_deframer_defines.svh @@
// Assertion macros used by the deframer RTL.
// Used by files that assert; expects signals clk and rst in scope.
`ifndef HEADER_TRAILER_DEFRAMER_DEFINES_SVH
`define HEADER_TRAILER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define HTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, ignored while in reset
`define HTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ rtl/core/htd_pkg.sv @@
// Package for the header/trailer deframer: sync byte constants, phase type,
// readout request struct and helper functions. No dependencies.
package htd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  // Payload length register width, also the width of all byte counts
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] LEN_RESET = 7'd64;

  localparam logic [7:0] HDR_A = 8'h1D;
  localparam logic [7:0] HDR_B = 8'hAC;
  localparam logic [7:0] TRL_A = 8'hFE;
  localparam logic [7:0] TRL_B = 8'hCA;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_DATA  = 3'd2,
    PH_TRL1  = 3'd3,
    PH_TRL2  = 3'd4
  } phase_t;

  // Request from the framer to start reading a completed frame out
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } emit_req_t;

  function automatic logic is_header(logic [7:0] b);
    return (b == HDR_A) || (b == HDR_B);
  endfunction

  function automatic logic is_trailer(logic [7:0] b);
    return (b == TRL_A) || (b == TRL_B);
  endfunction

  // Address width for a memory of the given depth
  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ rtl/core/htd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on htd_pkg for the address width helper.
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = htd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [htd_pkg::addr_w(DEPTH)-1:0]    wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [htd_pkg::addr_w(DEPTH)-1:0]    rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);
  import htd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/htd_framer.sv @@
// Frame sync state machine: hunts headers, writes payload beats to the
// store and checks trailers. Depends on htd_pkg.
module htd_framer #(
  parameter int MAX_PAYLOAD = htd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    hold,
  input  logic [7:0]                              rx_byte,
  input  logic [htd_pkg::CNT_W-1:0]               eff_len,
  output logic                                    wr_en,
  output logic [htd_pkg::addr_w(MAX_PAYLOAD)-1:0] wr_addr,
  output logic [7:0]                              wr_data,
  output htd_pkg::emit_req_t                      req
);
  import htd_pkg::*;

  localparam int AW = addr_w(MAX_PAYLOAD);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W:0]   count_inc;
  logic             accept;

  assign accept    = in_valid && !hold;
  assign count_inc = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};

  // Next phase and payload count
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (accept) begin
      unique case (phase)
        PH_HUNT1: begin
          phase_next = is_header(rx_byte) ? PH_HUNT2 : PH_HUNT1;
        end
        PH_HUNT2: begin
          phase_next = is_header(rx_byte) ? PH_DATA : PH_HUNT1;
          count_next = '0;
        end
        PH_DATA: begin
          // Leave payload once the count reaches the current length
          if (count_inc >= {1'b0, eff_len}) begin
            count_next = '0;
            phase_next = PH_TRL1;
          end else begin
            count_next = count_inc[CNT_W-1:0];
          end
        end
        PH_TRL1: begin
          phase_next = is_trailer(rx_byte) ? PH_TRL2 : PH_HUNT1;
        end
        PH_TRL2: begin
          phase_next = PH_HUNT1;
        end
        default: begin
          phase_next = is_header(rx_byte) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  // Store writes and readout request
  always_comb begin
    wr_en     = accept && (phase == PH_DATA);
    wr_addr   = AW'(count);
    wr_data   = rx_byte;
    req.start = accept && (phase == PH_TRL2) && is_trailer(rx_byte);
    req.len   = eff_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/core/htd_emit.sv @@
// Readout sequencer: reads a completed frame from the store and drives the
// output register, one beat per read. Depends on htd_pkg and the defines.
`include "header_trailer_deframer_defines.svh"

module htd_emit #(
  parameter int MAX_PAYLOAD = htd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  htd_pkg::emit_req_t                      req,
  input  logic                                    out_stall,
  input  logic [7:0]                              rd_data,
  output logic                                    rd_en,
  output logic [htd_pkg::addr_w(MAX_PAYLOAD)-1:0] rd_addr,
  output logic                                    busy,
  output logic                                    out_valid,
  output logic [7:0]                              payload_byte,
  output logic                                    last_of_frame
);
  import htd_pkg::*;

  localparam int AW = addr_w(MAX_PAYLOAD);

  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] len_q;
  logic             pending;
  logic             pending_last;
  logic             out_taken;
  logic             issue;
  logic             issue_last;

  assign out_taken  = out_valid && !out_stall;
  // Read only when the output register is free by the time data returns
  assign issue      = busy && !pending && (!out_valid || out_taken);
  assign issue_last = (rd_idx + CNT_W'(1)) == len_q;
  assign rd_en      = issue;
  assign rd_addr    = AW'(rd_idx);

  // Read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pending <= 1'b0;
      rd_idx  <= '0;
      len_q   <= '0;
    end else if (req.start) begin
      busy    <= 1'b1;
      pending <= 1'b0;
      rd_idx  <= '0;
      len_q   <= req.len;
    end else if (issue) begin
      pending <= 1'b1;
      rd_idx  <= rd_idx + CNT_W'(1);
      if (issue_last) begin
        busy <= 1'b0;
      end
    end else begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pending_last <= issue_last;
    end
  end

  // Output register: load returned data, drop on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pending) begin
      out_valid <= 1'b1;
    end else if (out_taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      payload_byte  <= rd_data;
      last_of_frame <= pending_last;
    end
  end

  `HTD_ASSERT_NEXT(a_pending_loads, pending, out_valid)
  `HTD_ASSERT_IMPL(a_idx_in_range, busy, rd_idx < len_q)
  `HTD_ASSERT_IMPL(a_start_when_idle, req.start, !busy && !pending)

endmodule

@@ rtl/core/header_trailer_deframer.sv @@
// Readout starts once the second trailer beat is taken: store read, then output register.
// Input takes one beat per cycle outside readout; readout issues a store read only once
// the previous beat has been loaded into the output register, so reads do not overlap.
// Input is stalled while the store is being read out.
// Reset (rst, synchronous) clears phase, count and readout state and sets the
// payload length to 64; the payload store is not cleared.
module header_trailer_deframer #(
  parameter int MAX_PAYLOAD = htd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  payload_byte,
  output logic                        last_of_frame,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [htd_pkg::CNT_W-1:0]   payload_length
);
  import htd_pkg::*;

  localparam int AW = addr_w(MAX_PAYLOAD);

  logic [CNT_W-1:0] len_reg;
  logic [CNT_W-1:0] eff_len;
  logic             busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  emit_req_t        req;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_reg <= payload_length;
    end
  end

  // Clamp length to one .. store depth
  always_comb begin
    if (len_reg == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(len_reg) > MAX_PAYLOAD) begin
      eff_len = CNT_W'(MAX_PAYLOAD);
    end else begin
      eff_len = len_reg;
    end
  end

  htd_framer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_framer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .hold     (busy),
    .rx_byte  (rx_byte),
    .eff_len  (eff_len),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .req      (req)
  );

  htd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htd_emit #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_emit (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .out_stall     (out_stall),
    .rd_data       (rd_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .busy          (busy),
    .out_valid     (out_valid),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame)
  );

endmodule

@@ tb/sv/header_trailer_deframer_test.sv @@
// Self-checking bench for header_trailer_deframer: directed and random frames,
// idle/stall phases, length register writes, checked against a built-in tracker.
// Depends on htd_pkg and the deframer RTL only.
module header_trailer_deframer_test;
  import htd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 180;
  localparam int BUSY_PCT       = 58;
  localparam int BOTH_PCT       = 13;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SETTLE_LIMIT   = 20000;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int MAX_SHOWN      = 10;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {FRAME_GOOD, FRAME_BAD_HDR, FRAME_BAD_TRL1, FRAME_BAD_TRL2} frame_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       payload_byte;
  logic             last_of_frame;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] payload_length = LEN_RESET;

  header_trailer_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_byte(payload_byte),
    .last_of_frame(last_of_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .payload_length(payload_length)
  );

  // Frame tracker state, mirrors the deframer
  phase_t           hunt_phase;
  logic [CNT_W-1:0] stored_count;
  logic [7:0]       frame_store [MAX_PAYLOAD_DEF];
  logic [CNT_W-1:0] length_reg;

  logic [7:0]       rx_bytes_due [$];
  payload_beat_t    payload_due [$];
  idle_mode_t       idle_mode = IDLE_NONE;
  logic             in_taken = 1'b0;
  logic [CNT_W-1:0] cur_len = LEN_RESET;

  int bytes_queued = 0;
  int bytes_taken = 0;
  int beats_checked = 0;
  int frames_checked = 0;
  int length_writes = 0;
  int error_count = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int effective_len(input logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PAYLOAD_DEF) return MAX_PAYLOAD_DEF;
    return int'(v);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("%s", msg);
  endfunction

  // Advance the tracker by one accepted byte; queue the payload run on a good trailer
  task automatic take_rx_byte(input logic [7:0] b);
    int            len;
    payload_beat_t beat;
    len = effective_len(length_reg);
    case (hunt_phase)
      PH_HUNT2: begin
        hunt_phase = (b == HDR_A || b == HDR_B) ? PH_DATA : PH_HUNT1;
        stored_count = '0;
      end
      PH_DATA: begin
        frame_store[stored_count] = b;
        stored_count = stored_count + 1'b1;
        if (stored_count >= len) begin
          stored_count = '0;
          hunt_phase = PH_TRL1;
        end
      end
      PH_TRL1: hunt_phase = (b == TRL_A || b == TRL_B) ? PH_TRL2 : PH_HUNT1;
      PH_TRL2: begin
        if (b == TRL_A || b == TRL_B) begin
          for (int i = 0; i < len; i++) begin
            beat.data = frame_store[i];
            beat.last = (i == len - 1);
            payload_due.push_back(beat);
          end
        end
        hunt_phase = PH_HUNT1;
      end
      default: hunt_phase = (b == HDR_A || b == HDR_B) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin : sample_edge
    payload_beat_t want;
    in_taken <= in_valid && !in_stall && !rst;
    if (rst) begin
      hunt_phase = PH_HUNT1;
      stored_count = '0;
      length_reg = LEN_RESET;
    end else begin
      // The byte taken at this edge still sees the old length
      if (in_valid && !in_stall) begin
        take_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        length_reg = payload_length;
        length_writes++;
      end
      if (out_valid && !out_stall) begin
        if (payload_due.size() == 0) begin
          note_error($sformatf("unexpected payload beat: data %02h last %0b",
                               payload_byte, last_of_frame));
        end else begin
          want = payload_due.pop_front();
          if (payload_byte !== want.data)
            note_error($sformatf("payload_byte mismatch: expected %02h, got %02h",
                                 want.data, payload_byte));
          if (last_of_frame !== want.last)
            note_error($sformatf("last_of_frame mismatch on %02h: expected %0b, got %0b",
                                 want.data, want.last, last_of_frame));
          beats_checked++;
          if (want.last) frames_checked++;
        end
      end
    end
  end

  // Drive the byte channel and the receiver stall at the falling edge
  always @(negedge clk) begin : drive_edge
    logic hold_off;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      hold_off = (idle_mode == IDLE_SEND && $urandom_range(99) < BUSY_PCT) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(99) < BOTH_PCT);
      if (rx_bytes_due.size() != 0 && !hold_off) begin
        rx_byte  <= rx_bytes_due.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    case (idle_mode)
      IDLE_RECV: out_stall <= ($urandom_range(99) < BUSY_PCT);
      IDLE_BOTH: out_stall <= ($urandom_range(99) < BOTH_PCT);
      default:   out_stall <= 1'b0;
    endcase
  end

  function automatic logic [7:0] pick_sync(input logic [7:0] a, input logic [7:0] b);
    return $urandom_range(1) ? a : b;
  endfunction

  function automatic logic [7:0] pick_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b);
    return v;
  endfunction

  // Mostly short lengths; now and then zero, full size and oversized values
  function automatic logic [CNT_W-1:0] pick_length_cfg();
    int r;
    r = $urandom_range(99);
    if (r < 62) return CNT_W'($urandom_range(1, 8));
    if (r < 76) return CNT_W'($urandom_range(9, 24));
    if (r < 82) return '0;
    if (r < 88) return CNT_W'(MAX_PAYLOAD_DEF);
    if (r < 94) return CNT_W'($urandom_range(MAX_PAYLOAD_DEF + 1, 126));
    return {CNT_W{1'b1}};
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_due.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input frame_kind_t kind, input int len);
    queue_byte(pick_sync(HDR_A, HDR_B));
    if (kind == FRAME_BAD_HDR) begin
      queue_byte(pick_byte_except(HDR_A, HDR_B));
      return;
    end
    queue_byte(pick_sync(HDR_A, HDR_B));
    repeat (len) queue_byte(8'($urandom_range(255)));
    if (kind == FRAME_BAD_TRL1) begin
      queue_byte(pick_byte_except(TRL_A, TRL_B));
      return;
    end
    queue_byte(pick_sync(TRL_A, TRL_B));
    queue_byte(kind == FRAME_BAD_TRL2 ? pick_byte_except(TRL_A, TRL_B)
                                      : pick_sync(TRL_A, TRL_B));
  endtask

  // Hold until every queued byte has been taken; return on a rising edge
  task automatic wait_sent();
    while (bytes_taken != bytes_queued) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold until bytes and payload beats are all through, then let the block settle
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || payload_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] v);
    int seen;
    seen = length_writes;
    @(negedge clk);
    cfg_valid      <= 1'b1;
    payload_length <= v;
    while (length_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = v;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int random_base;
    int noise_bytes;
    int segment;
    int n_frames;
    int old_len;
    int new_len;
    int held;
    int rest;
    int r;
    int settle;
    logic [CNT_W-1:0] new_cfg;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero length acts as one; lowest byte value
    write_length('0);
    queue_byte(HDR_A); queue_byte(HDR_B); queue_byte(8'h00);
    queue_byte(TRL_A); queue_byte(TRL_B);
    wait_drained();

    // Swapped sync bytes, top byte value, then the three ways a frame breaks
    write_length(7'd2);
    queue_byte(HDR_B); queue_byte(HDR_A); queue_byte(8'hFF); queue_byte(8'h80);
    queue_byte(TRL_B); queue_byte(TRL_A);
    queue_byte(HDR_A); queue_byte(8'h1C);
    queue_byte(HDR_A); queue_byte(HDR_A); queue_byte(8'h55); queue_byte(8'hAA);
    queue_byte(8'hCB);
    queue_byte(HDR_B); queue_byte(HDR_B); queue_byte(8'h11); queue_byte(8'h22);
    queue_byte(TRL_A); queue_byte(8'hFF);
    wait_drained();

    random_base = bytes_queued;
    noise_bytes = 0;
    segment = 0;
    while (bytes_queued - random_base - noise_bytes < RANDOM_ITEMS) begin
      idle_mode = idle_mode_t'(segment % 4);
      if (segment == 0 || $urandom_range(5) == 0) begin
        // Change the length part-way through a payload, sender held meanwhile
        old_len = effective_len(cur_len);
        held = $urandom_range(0, old_len - 1);
        queue_byte(pick_sync(HDR_A, HDR_B));
        queue_byte(pick_sync(HDR_A, HDR_B));
        repeat (held) queue_byte(8'($urandom_range(255)));
        wait_drained();
        new_cfg = pick_length_cfg();
        write_length(new_cfg);
        new_len = effective_len(new_cfg);
        rest = (held >= new_len) ? 1 : new_len - held;
        repeat (rest) queue_byte(8'($urandom_range(255)));
        queue_byte(pick_sync(TRL_A, TRL_B));
        queue_byte(pick_sync(TRL_A, TRL_B));
      end else if ($urandom_range(2) == 0) begin
        wait_drained();
        write_length(pick_length_cfg());
      end
      n_frames = (effective_len(cur_len) > 24) ? 1 : $urandom_range(1, 4);
      repeat (n_frames) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            queue_byte(pick_byte_except(HDR_A, HDR_B));
            noise_bytes++;
          end
        end
        r = $urandom_range(99);
        queue_frame(r < 76 ? FRAME_GOOD : r < 84 ? FRAME_BAD_HDR :
                    r < 92 ? FRAME_BAD_TRL1 : FRAME_BAD_TRL2, effective_len(cur_len));
      end
      wait_sent();
      segment++;
    end

    // Let the last frames drain, with a bound
    settle = 0;
    while ((bytes_taken != bytes_queued || payload_due.size() != 0) && settle < SETTLE_LIMIT) begin
      @(negedge clk);
      settle++;
    end
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    if (bytes_taken != bytes_queued)
      note_error($sformatf("%0d bytes never accepted", bytes_queued - bytes_taken));
    if (payload_due.size() != 0) begin
      note_error($sformatf("%0d payload beats never arrived", payload_due.size()));
      error_count += payload_due.size() - 1;
    end

    $display("Run covered %0d bytes (%0d noise) over %0d random segments and %0d length writes.",
             bytes_taken, noise_bytes, segment, length_writes);
    $display("Checked %0d payload beats in %0d completed frames; %0d errors.",
             beats_checked, frames_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Bound the whole run
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Run timed out");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ header_trailer_deframer.f @@
+incdir+rtl/core
rtl/core/htd_pkg.sv
rtl/core/htd_ram.sv
rtl/core/htd_framer.sv
rtl/core/htd_emit.sv
rtl/core/header_trailer_deframer.sv
tb/sv/header_trailer_deframer_test.sv
